[design/isort_pkg.sv]
// Shared types and constants for the insertion sorter.
`timescale 1ns / 1ps
package isort_pkg;

   // Number of sorting cells (store capacity), 1 to 64.
   localparam int SIZE = 16;
   localparam int VALUE_W = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_set;
      logic                      overflow;
   } rsp_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic load;        // insert new_value this cycle
      logic shift;       // move contents one cell toward cell 0
      logic descending;  // ordering used for the comparison
   } cell_ctrl_type;

endpackage

[design/isort_cell.sv]
// One compare-and-shift cell of the insertion sorter chain.
`timescale 1ns / 1ps
module isort_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  isort_pkg::cell_ctrl_type             ctrl,
   input  logic signed [isort_pkg::VALUE_W-1:0] new_value,
   input  logic signed [isort_pkg::VALUE_W-1:0] left_value,
   input  logic                                 left_occ,
   input  logic                                 left_ins,
   input  logic signed [isort_pkg::VALUE_W-1:0] right_value,
   input  logic                                 right_occ,
   input  logic                                 right_ins,
   output logic signed [isort_pkg::VALUE_W-1:0] value,
   output logic                                 occ,
   output logic                                 ins
);
   import isort_pkg::*;

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      occ_ff, occ_in;
   logic                      precedes;

   // Strict compare: equal keys go behind the stored one.
   assign precedes = ctrl.descending ? (new_value > value_ff) : (new_value < value_ff);
   // An empty cell always counts as the insertion point or beyond it. An occupied
   // cell is at or past the insertion point only if the new value precedes it and
   // every occupied cell to its right, so the chain stays exact even when the
   // order was changed in the middle of a set.
   assign ins = !occ_ff || (precedes && right_ins);

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      if (ctrl.load && ins) begin
         value_in = left_ins ? left_value : new_value;
         occ_in   = occ_ff || left_occ;
      end else if (ctrl.shift) begin
         value_in = right_value;
         occ_in   = right_occ;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign value = value_ff;
   assign occ   = occ_ff;

endmodule

[design/insertion_sorter.sv]
// Top level of the insertion sorter: cell chain, sequencer and result register.
`timescale 1ns / 1ps
// Insertion sorter. Signed 32-bit values arrive one transaction at a time on
// the req_ channel and are inserted into a chain of SIZE cells (isort_pkg)
// that always holds the current set in sorted order; csr_write_data selects
// ascending (0) or descending (1) order for later insertions. On loading,
// every cell compares the new value in parallel, the insertion point is the
// start of the trailing run of stored values that the new value strictly
// precedes, and the cells from there on move one place toward the end, so
// back-to-back input is accepted while the set is being built. Equal values
// keep arrival order. Values that arrive while all cells are full are dropped
// and the overflow bit is set on every result of that set. Once the value
// marked last_item is taken, req_ready falls and the chain drains from cell 0
// through a single output register at one result per cycle (as rsp_ready
// allows); end_of_set marks the final result, after which the chain is empty
// and req_ready returns. A transaction can be accepted while the final result
// of the previous set still waits in the output register.
module insertion_sorter (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  isort_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output isort_pkg::rsp_type  rsp_payload,
   input  logic                csr_write_enable,
   input  logic                csr_write_data
);
   import isort_pkg::*;

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic          state_ff, state_in;
   logic          descending_ff, descending_in;
   logic          dropped_ff, dropped_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   cell_ctrl_type ctrl;
   logic          req_accept;
   logic          full;
   logic          pop;
   logic          pop_last;

   // Cell taps; index SIZE is the empty position past the end of the chain.
   logic signed [VALUE_W-1:0] cell_value [0:SIZE];
   logic [SIZE:0]             cell_occ;
   logic [SIZE:0]             cell_ins;

   assign cell_value[SIZE] = '0;
   assign cell_occ[SIZE]   = 1'b0;
   assign cell_ins[SIZE]   = 1'b1;

   genvar gi;
   generate
      for (gi = 0; gi < SIZE; gi++) begin : g_cell
         logic signed [VALUE_W-1:0] left_value;
         logic                      left_occ;
         logic                      left_ins;
         if (gi == 0) begin : g_head
            // Head cell: nothing to its left ever moves in.
            assign left_value = req_payload.value;
            assign left_occ   = 1'b1;
            assign left_ins   = 1'b0;
         end else begin : g_body
            assign left_value = cell_value[gi-1];
            assign left_occ   = cell_occ[gi-1];
            assign left_ins   = cell_ins[gi-1];
         end
         isort_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_value   (req_payload.value),
            .left_value  (left_value),
            .left_occ    (left_occ),
            .left_ins    (left_ins),
            .right_value (cell_value[gi+1]),
            .right_occ   (cell_occ[gi+1]),
            .right_ins   (cell_ins[gi+1]),
            .value       (cell_value[gi]),
            .occ         (cell_occ[gi]),
            .ins         (cell_ins[gi])
         );
      end
   endgenerate

   assign req_ready  = (state_ff == ST_LOAD);
   assign req_accept = req_valid && req_ready;
   assign full       = cell_occ[SIZE-1];

   // Pop cell 0 into the output register whenever it is free or being taken.
   assign pop      = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);
   assign pop_last = pop && !cell_occ[1];

   always_comb begin
      ctrl.load       = req_accept && !full;
      ctrl.shift      = pop;
      ctrl.descending = descending_ff;
   end

   always_comb begin
      state_in      = state_ff;
      descending_in = descending_ff;
      dropped_in    = dropped_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (csr_write_enable) begin
         descending_in = csr_write_data;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end
               if (req_payload.last_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (pop_last) begin
               state_in   = ST_LOAD;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (pop) begin
         rsp_valid_in        = 1'b1;
         rsp_in.sorted_value = cell_value[0];
         rsp_in.end_of_set   = !cell_occ[1];
         rsp_in.overflow     = dropped_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff      <= ST_LOAD;
         descending_ff <= 1'b0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         descending_ff <= descending_in;
         dropped_ff    <= dropped_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Occupied cells always form an unbroken run starting at cell 0.
   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      ((cell_occ + 1'b1) & cell_occ) == '0)
      else $error("cell occupancy is not contiguous");

   // A set never drains from an empty chain.
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> cell_occ[0])
      else $error("draining with cell 0 empty");

   // The last transaction of a set closes the input until the set is emitted.
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.last_item) |=> !req_ready)
      else $error("input still open after last item");

   // After the final result is popped the chain is empty and overflow cleared.
   a_set_done: assert property (@(posedge clock) disable iff (reset)
      pop_last |=> (cell_occ == '0) && !dropped_ff && rsp_valid && rsp_payload.end_of_set)
      else $error("chain not emptied at end of set");

endmodule
